[hdl/sssd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, opcodes and glyph table for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

   localparam int unsigned DIGITS_DEFAULT = 4;
   localparam int unsigned MAX_DIGITS     = 8;
   localparam int unsigned SEL_W          = 4;

   localparam logic [7:0] GLYPH_ZERO    = 8'hC0;
   localparam logic [7:0] GLYPH_BLANK   = 8'hFF;
   localparam logic [7:0] DOT_KEEP_MASK = 8'h7F;

   localparam logic [7:0] HEX_GLYPH [16] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
   };

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SHOW4   = 2'd1,
      OP_SHOW3   = 2'd2,
      OP_SET_DOT = 2'd3
   } op_type;

   typedef struct packed {
      logic [6:0] thousands;
      logic [9:0] hundreds_all;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
   } split_type;

   typedef struct packed {
      logic   fire;
      op_type op;
   } cmd_type;

   function automatic logic [7:0] glyph_of(logic [7:0] code);
      logic [7:0] g;
      g = GLYPH_BLANK;
      if (code < 8'd16) begin
         g = HEX_GLYPH[code[3:0]];
      end
      return g;
   endfunction

endpackage

[hdl/sssd_split.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_split
// Decimal split of a 16-bit value by reciprocal multiplication.
// ----------------------------------------------------------------------------
module sssd_split (
   input  logic [15:0]          value,
   output sssd_pkg::split_type  split
);
   import sssd_pkg::*;

   localparam logic [16:0] RECIP_1000 = 17'd67109;
   localparam logic [17:0] RECIP_100  = 18'd167773;
   localparam logic [15:0] RECIP_10   = 16'd52429;

   logic [32:0] prod_1000;
   logic [33:0] prod_100;
   logic [31:0] prod_10;
   logic [6:0]  q1000;
   logic [9:0]  q100;
   logic [12:0] q10;
   logic [9:0]  rem_100;
   logic [12:0] rem_10;
   logic [15:0] rem_1;

   assign prod_1000 = 33'(value) * 33'(RECIP_1000);
   assign prod_100  = 34'(value) * 34'(RECIP_100);
   assign prod_10   = 32'(value) * 32'(RECIP_10);

   assign q1000 = prod_1000[32:26];
   assign q100  = prod_100[33:24];
   assign q10   = prod_10[31:19];

   assign rem_100 = q100  - (10'({q1000, 3'b000}) + 10'({q1000, 1'b0}));
   assign rem_10  = q10   - (13'({q100, 3'b000}) + 13'({q100, 1'b0}));
   assign rem_1   = value - ({q10, 3'b000} + 16'({q10, 1'b0}));

   assign split.thousands    = q1000;
   assign split.hundreds_all = q100;
   assign split.hundreds     = rem_100[3:0];
   assign split.tens         = rem_10[3:0];
   assign split.units        = rem_1[3:0];

endmodule

[hdl/sssd_display.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_display
// Glyph store, dot tracking and scan counter; forms one digit beat per tick.
// ----------------------------------------------------------------------------
module sssd_display #(
   parameter int unsigned DIGITS = sssd_pkg::DIGITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sssd_pkg::cmd_type           cmd,
   input  logic [7:0]                  dot_arg,
   input  sssd_pkg::split_type         split,
   output logic [7:0]                  seg,
   output logic [sssd_pkg::SEL_W-1:0]  sel
);
   import sssd_pkg::*;

   localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [7:0]       glyph_ff   [DIGITS];
   logic [7:0]       glyph_in   [DIGITS];
   logic [7:0]       tick_glyph [DIGITS];
   logic [7:0]       dot_ff;
   logic [7:0]       dot_in;
   logic             prev_valid_ff;
   logic             prev_valid_in;
   logic [IDX_W-1:0] prev_idx_ff;
   logic [IDX_W-1:0] prev_idx_in;
   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] scan_idx_in;
   logic             dot_ok;
   logic [7:0]       show4_code [MAX_DIGITS];
   logic [7:0]       show3_code [MAX_DIGITS];

   assign dot_ok = (dot_ff < 8'(DIGITS));

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         show4_code[i] = '0;
         show3_code[i] = '0;
      end
      show4_code[0] = {1'b0, split.thousands};
      show4_code[1] = {4'b0000, split.hundreds};
      show4_code[2] = {4'b0000, split.tens};
      show4_code[3] = {4'b0000, split.units};
      show3_code[0] = split.hundreds_all[7:0];
      show3_code[1] = {4'b0000, split.tens};
      show3_code[2] = {4'b0000, split.units};
   end

   // restore the old dot, then clear the current one
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         tick_glyph[i] = glyph_ff[i];
         if (prev_valid_ff && (prev_idx_ff == IDX_W'(i))) begin
            tick_glyph[i] = tick_glyph[i] | ~DOT_KEEP_MASK;
         end
         if (dot_ok && (dot_ff == 8'(i))) begin
            tick_glyph[i] = tick_glyph[i] & DOT_KEEP_MASK;
         end
      end
   end

   always_comb begin
      seg = tick_glyph[scan_idx_ff];
      sel = '1;
      if (32'(scan_idx_ff) < 32'(SEL_W)) begin
         sel = ~(SEL_W'(1) << scan_idx_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         glyph_in[i] = glyph_ff[i];
      end
      dot_in        = dot_ff;
      prev_valid_in = prev_valid_ff;
      prev_idx_in   = prev_idx_ff;
      scan_idx_in   = scan_idx_ff;
      if (cmd.fire) begin
         unique case (cmd.op)
            OP_TICK: begin
               for (int i = 0; i < DIGITS; i++) begin
                  glyph_in[i] = tick_glyph[i];
               end
               if (dot_ok) begin
                  prev_valid_in = 1'b1;
                  prev_idx_in   = dot_ff[IDX_W-1:0];
               end
               if (scan_idx_ff == IDX_W'(DIGITS - 1)) begin
                  scan_idx_in = '0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            OP_SHOW4: begin
               for (int i = 0; i < DIGITS; i++) begin
                  if (i < 4) begin
                     glyph_in[i] = glyph_of(show4_code[i]);
                  end
               end
            end
            OP_SHOW3: begin
               for (int i = 0; i < DIGITS; i++) begin
                  if (i < 3) begin
                     glyph_in[i] = glyph_of(show3_code[i]);
                  end
               end
            end
            OP_SET_DOT: begin
               dot_in = dot_arg;
            end
            default: begin
               dot_in = dot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) begin
            glyph_ff[i] <= GLYPH_ZERO;
         end
         dot_ff        <= 8'(DIGITS);
         prev_valid_ff <= 1'b0;
         prev_idx_ff   <= '0;
         scan_idx_ff   <= '0;
      end else begin
         for (int i = 0; i < DIGITS; i++) begin
            glyph_ff[i] <= glyph_in[i];
         end
         dot_ff        <= dot_in;
         prev_valid_ff <= prev_valid_in;
         prev_idx_ff   <= prev_idx_in;
         scan_idx_ff   <= scan_idx_in;
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_idx_ff <= IDX_W'(DIGITS - 1))
      else $error("scan index beyond last digit");

   a_prev_in_range: assert property (@(posedge clock) disable iff (reset)
      prev_valid_ff |-> (prev_idx_ff <= IDX_W'(DIGITS - 1)))
      else $error("previous dot beyond last digit");

endmodule

[hdl/seven_segment_scan_driver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment driver: decimal writes, dot placement and
// scan ticks, one digit beat out per tick.
//
//   channel  dir  fields (low bit first)
//   req      in   tuser: op[1:0]; tdata: value[15:0]
//   rsp      out  tdata: seg_pattern[7:0], digit_select_n[11:8], zero[15:12]
//
// One beat per cycle sustained while rsp is not stalled.
// Input register, then decimal split and state update, then result register.
// Reset clears the glyphs to zero, the scan to digit 0 and the dot to none.
// A stalled result holds only ticks; writes and dot beats keep flowing.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
   parameter int unsigned DIGITS = sssd_pkg::DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // seg_pattern[7:0], digit_select_n[11:8], zero
);
   import sssd_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   op_type             in_op_ff;
   logic [15:0]        in_value_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_seg_ff;
   logic [SEL_W-1:0]   rsp_sel_ff;
   logic               out_free;
   logic               exec_fire;
   cmd_type            cmd;
   split_type          split;
   logic [7:0]         seg;
   logic [SEL_W-1:0]   sel;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec_fire  = in_valid_ff && ((in_op_ff != OP_TICK) || out_free);
   assign req_tready = !in_valid_ff || exec_fire;

   assign cmd.fire = exec_fire;
   assign cmd.op   = in_op_ff;

   sssd_split u_split (
      .value (in_value_ff),
      .split (split)
   );

   sssd_display #(
      .DIGITS (DIGITS)
   ) u_display (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .dot_arg (in_value_ff[7:0]),
      .split   (split),
      .seg     (seg),
      .sel     (sel)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire && (in_op_ff == OP_TICK)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= op_type'(req_tuser);
         in_value_ff <= req_tdata;
      end
      if (exec_fire && (in_op_ff == OP_TICK)) begin
         rsp_seg_ff <= seg;
         rsp_sel_ff <= sel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_sel_ff, rsp_seg_ff};

   a_tick_makes_beat: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (in_op_ff == OP_TICK)) |=> rsp_valid_ff)
      else $error("tick left no result beat");

   a_write_no_beat: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (in_op_ff != OP_TICK) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("write produced a result beat");

   a_one_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((DIGITS > SEL_W) || ($countones(rsp_sel_ff) == SEL_W - 1)))
      else $error("digit enables not exactly one low");

endmodule
